// File: rtl/core/sorted_linear_quantiles_assert.svh
// Assertion macros shared by the sorted_linear_quantiles RTL.
// No dependencies; included by the files that assert.
`ifndef SORTED_LINEAR_QUANTILES_ASSERT_SVH
`define SORTED_LINEAR_QUANTILES_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SLQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define SLQ_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

// File: rtl/core/slq_pkg.sv
// Package for sorted_linear_quantiles: payload types, register indexes, sizes.
// No dependencies.
package slq_pkg;
  localparam int MaxSamples = 64;
  localparam int ProbSlots  = 4;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int SlotW      = 2;

  localparam logic [2:0] RegProbCount = 3'd0;
  localparam logic [2:0] RegProbA     = 3'd1;
  localparam logic [2:0] RegProbD     = 3'd4;
  localparam logic [2:0] RegNaRemove  = 3'd5;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               sample_missing;
    logic               set_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] quantile_value;
    logic               value_missing;
    logic [1:0]         prob_slot;
    logic               result_last;
  } out_item_t;

  // Memory request from the sequencer to the sample store.
  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic signed [31:0] wdata;
    logic [AddrW-1:0]   raddr;
  } mem_req_t;
endpackage

// File: rtl/core/slq_store.sv
// Sample store of sorted_linear_quantiles: one write port, one registered read.
// Depends on slq_pkg.
module slq_store import slq_pkg::*; (
  input  logic               clk_i,
  input  mem_req_t           req_i,
  output logic signed [31:0] rdata_o
);
  logic signed [31:0] mem_q [MaxSamples];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

// File: rtl/core/sorted_linear_quantiles.sv
// sorted_linear_quantiles: collects a set of signed Q16.16 samples, keeping the
// valid ones sorted by insertion in a 64-entry synchronous memory, and on the
// sample flagged set_last emits one type-7 interpolated quantile per configured
// probability. Insertion walks the memory from the top, one read and one
// shifting write per cycle, moving each larger stored sample up by one entry
// before the new sample is written; missing or over-capacity samples are not
// stored. For each probability the emit phase chooses the case, reads the
// lower and then the upper order statistic, multiplies, adds when the fraction
// is nonzero, and outputs; when a special case decides the result it goes
// straight from the choice to the output. A stalled output register holds the
// emit phase. Results leave through an output register; input stall is high
// whenever the control is not idle, during an insertion and the emit phase.
`include "sorted_linear_quantiles_assert.svh"
module sorted_linear_quantiles import slq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_INS  = 9'b000000010, // compare store[i-1] with the new value
    S_EMIT = 9'b000000100, // choose the case for one slot
    S_RLO  = 9'b000001000, // read lower order statistic
    S_RHI  = 9'b000010000, // read upper
    S_MUL  = 9'b000100000,
    S_ADD  = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_WAIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]  prob_count_q;
  logic [16:0] prob_q [ProbSlots];
  logic        na_remove_q;

  logic [CntW-1:0] valid_count_q, raw_count_q, idx_q;
  logic            missing_seen_q, first_missing_q;
  logic signed [31:0] first_value_q, new_q, lo_q, res_value_q;
  logic            res_missing_q; // result of the current slot, held until output
  logic [1:0]      slot_q;
  logic [2:0]      count_q;
  logic [15:0]     frac_q;
  logic signed [49:0] prod_q;
  out_item_t       out_q;
  logic            out_v_q;

  mem_req_t req;
  logic signed [31:0] rdata;

  slq_store u_store (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_free = !out_v_q || !out_stall_i;

  // Position of the current slot's probability in the sorted set.
  logic [16:0] p_sat;
  logic [CntW+16:0] pos;
  logic [CntW-1:0] lo_idx;
  always_comb begin
    p_sat  = prob_q[slot_q] > 17'd65536 ? 17'd65536 : prob_q[slot_q];
    pos    = p_sat * (CntW+17)'(valid_count_q - 1'b1);
    lo_idx = pos[CntW+15:16];
    if (lo_idx >= valid_count_q) lo_idx = valid_count_q - 1'b1;
  end

  always_comb begin
    req = '0;
    req.raddr = AddrW'(idx_q - 1'b1);
    // An accepted sample compares first against the largest stored one.
    if (state_q == S_IDLE) req.raddr = AddrW'(valid_count_q - 1'b1);
    if (state_q == S_INS) begin
      if (idx_q != '0 && rdata > new_q) begin
        req.we = 1'b1; req.waddr = AddrW'(idx_q); req.wdata = rdata;
        req.raddr = AddrW'(idx_q - 2'd2);
      end else begin
        req.we = 1'b1; req.waddr = AddrW'(idx_q); req.wdata = new_q;
      end
    end
    if (state_q == S_RLO) req.raddr = AddrW'(lo_idx);
    if (state_q == S_RHI) req.raddr = AddrW'(lo_idx + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; prob_count_q <= 3'd1; na_remove_q <= 1'b0;
      for (int k = 0; k < ProbSlots; k++) prob_q[k] <= 17'd32768;
      valid_count_q <= '0; raw_count_q <= '0; missing_seen_q <= 1'b0;
      first_missing_q <= 1'b0; first_value_q <= '0; out_v_q <= 1'b0;
      idx_q <= '0; slot_q <= '0; count_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegProbCount) prob_count_q <= cfg_data_i[2:0];
        else if (cfg_index_i >= RegProbA && cfg_index_i <= RegProbD)
          prob_q[2'(cfg_index_i - RegProbA)] <= cfg_data_i[16:0];
        else if (cfg_index_i == RegNaRemove) na_remove_q <= cfg_data_i[0];
      end
      if (state_q == S_OUT && out_free) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_xfer) begin
          slot_q  <= '0;
          count_q <= (prob_count_q == 3'd0) ? 3'd1 :
                     (prob_count_q > 3'(ProbSlots)) ? 3'(ProbSlots) : prob_count_q;
          if (raw_count_q < CntW'(MaxSamples)) begin
            if (raw_count_q == '0) begin
              first_value_q <= in_data_i.sample;
              first_missing_q <= in_data_i.sample_missing;
            end
            raw_count_q <= raw_count_q + 1'b1;
            if (in_data_i.sample_missing) missing_seen_q <= 1'b1;
            else begin
              new_q <= in_data_i.sample; idx_q <= valid_count_q;
              state_q <= S_INS;
            end
          end
          if (state_d == S_EMIT || !(raw_count_q < CntW'(MaxSamples)) ||
              in_data_i.sample_missing)
            if (in_data_i.set_last) state_q <= S_EMIT;
        end
        S_INS: begin
          if (idx_q != '0 && rdata > new_q) begin
            idx_q <= idx_q - 1'b1;
          end else begin
            valid_count_q <= valid_count_q + 1'b1;
            state_q <= state_d;
          end
        end
        S_EMIT: begin
          if (raw_count_q == CntW'(1)) begin
            res_value_q <= first_missing_q ? '0 : first_value_q;
            res_missing_q <= first_missing_q; state_q <= S_OUT;
          end else if ((missing_seen_q && !na_remove_q) || valid_count_q == '0) begin
            res_value_q <= '0; res_missing_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            frac_q <= pos[15:0]; state_q <= S_RLO;
          end
        end
        S_RLO: state_q <= S_RHI;
        S_RHI: begin lo_q <= rdata; state_q <= S_MUL; end
        S_MUL: begin
          if (frac_q == '0 || lo_idx + 1'b1 >= valid_count_q) begin
            res_value_q <= lo_q; res_missing_q <= 1'b0;
            state_q <= S_OUT;
          end else state_q <= S_ADD;
          prod_q <= (33'(rdata) - 33'(lo_q)) * $signed({1'b0, frac_q});
        end
        S_ADD: begin
          res_value_q <= lo_q + 32'(prod_q >>> 16);
          res_missing_q <= 1'b0; state_q <= S_OUT;
        end
        S_OUT: if (out_free) begin
          out_q.quantile_value <= res_value_q;
          out_q.value_missing <= res_missing_q;
          out_q.prob_slot <= slot_q;
          out_q.result_last <= (3'(slot_q) + 3'd1 == count_q);
          if (3'(slot_q) + 3'd1 == count_q) begin
            valid_count_q <= '0; raw_count_q <= '0; missing_seen_q <= 1'b0;
            first_value_q <= '0; first_missing_q <= 1'b0; state_q <= S_IDLE;
          end else begin
            slot_q <= slot_q + 1'b1; state_q <= S_EMIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // After insertion: go on to emit when the sample closed the set.
  logic last_q;
  always_ff @(posedge clk_i) if (in_xfer) last_q <= in_data_i.set_last;
  always_comb state_d = (state_q == S_INS && last_q) ? S_EMIT : S_IDLE;

  `SLQ_NEVER(a_cnt_order, clk_i, rst_ni, valid_count_q > raw_count_q,
    "more sorted samples than raw samples")
  `SLQ_ASSERT(a_out_hold, clk_i, rst_ni, out_v_q && out_stall_i |=> $stable(out_q),
    "stalled result changed")
  `SLQ_ASSERT(a_stall_busy, clk_i, rst_ni, state_q == S_INS |-> in_stall_o,
    "input accepted during insertion")
endmodule

// File: test/sorted_linear_quantiles_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_linear_quantiles: drives sample sets, predicts the quantiles
// in its own model of the block and checks every result transfer. Depends on slq_pkg.
module sorted_linear_quantiles_tb;
  import slq_pkg::*;

  localparam logic [2:0] RegProbB = 3'd2;
  localparam logic [2:0] RegProbC = 3'd3;
  localparam logic [2:0] RegBad   = 3'd7;
  localparam int unsigned OneQ16  = 65536;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  sorted_linear_quantiles DUT (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: configuration and the set being collected.
  int unsigned       cur_prob_count;
  int unsigned       cur_prob [4];
  bit                cur_na_remove;
  logic signed [31:0] sorted_vals [$];
  int unsigned       raw_seen;
  bit                any_missing;
  logic signed [31:0] first_value;
  bit                first_missing;

  in_item_t  pending_samples [$];
  out_item_t expected_quantiles [$];
  int        mismatch_count = 0;
  bit        hold_receiver = 1'b0;
  bit        stim_done = 1'b0;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_collected();
    sorted_vals.delete();
    raw_seen = 0;
    any_missing = 0;
    first_value = '0;
    first_missing = 0;
  endfunction

  function automatic logic signed [31:0] interpolate(input int unsigned p);
    longint unsigned pos;
    int unsigned lo_idx, frac, n;
    longint signed lo, hi, d;
    n = sorted_vals.size();
    if (p > OneQ16) p = OneQ16;
    pos = longint'(p) * longint'(n - 1);
    lo_idx = 32'(pos >> 16);
    frac = 32'(pos & 64'hFFFF);
    if (lo_idx >= n) lo_idx = n - 1;
    lo = sorted_vals[lo_idx];
    if (frac == 0 || lo_idx + 1 >= n) return lo[31:0];
    hi = sorted_vals[lo_idx + 1];
    d = (hi - lo) * longint'(frac);
    return 32'(lo + (d >>> 16));
  endfunction

  // Predicts the quantiles caused by one accepted sample.
  function automatic void predict_quantiles(input in_item_t it);
    int unsigned cnt, idx;
    out_item_t r;
    if (raw_seen < MaxSamples) begin
      if (raw_seen == 0) begin
        first_value = it.sample;
        first_missing = it.sample_missing;
      end
      raw_seen++;
      if (it.sample_missing) begin
        any_missing = 1;
      end else begin
        idx = sorted_vals.size();
        while (idx > 0 && sorted_vals[idx-1] > it.sample) idx--;
        sorted_vals.insert(idx, it.sample);
      end
    end
    if (!it.set_last) return;
    cnt = cur_prob_count;
    if (cnt < 1) cnt = 1;
    if (cnt > ProbSlots) cnt = ProbSlots;
    for (int unsigned k = 0; k < cnt; k++) begin
      r = '0;
      if (raw_seen == 1) begin
        r.value_missing = first_missing;
        r.quantile_value = first_missing ? '0 : first_value;
      end else if ((any_missing && !cur_na_remove) || sorted_vals.size() == 0) begin
        r.value_missing = 1'b1;
      end else begin
        r.quantile_value = interpolate(cur_prob[k]);
      end
      r.prob_slot = k[1:0];
      r.result_last = (k + 1 == cnt);
      expected_quantiles.push_back(r);
    end
    clear_collected();
  endfunction

  // Driver: offers queued samples with random gaps; holds payload while stalled.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_quantiles(in_data_i);
        send_gap = gap_len();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data_i <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls on the result side and field-by-field checks.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_quantiles.size() == 0) begin
          report_mismatch("result transfer with no expected quantile");
        end else begin
          e = expected_quantiles.pop_front();
          if (out_data_o.quantile_value !== e.quantile_value)
            report_mismatch($sformatf("quantile_value %0d, expected %0d",
                                      out_data_o.quantile_value, e.quantile_value));
          if (out_data_o.value_missing !== e.value_missing)
            report_mismatch("value_missing differs");
          if (out_data_o.prob_slot !== e.prob_slot)
            report_mismatch("prob_slot differs");
          if (out_data_o.result_last !== e.result_last)
            report_mismatch("result_last differs");
        end
      end
      out_stall_i <= hold_receiver || ($urandom_range(0, 99) < 25);
    end
  end

  // One write transfer, after which valid is low again so back-to-back writes never overlap.
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_index_i <= index;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      RegProbCount: cur_prob_count = value[2:0];
      RegProbA, RegProbB, RegProbC, RegProbD: cur_prob[index - RegProbA] = value[16:0];
      RegNaRemove: cur_na_remove = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Waits until the block has drained, then a margin for a set still in flight.
  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid_i || expected_quantiles.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic in_item_t make_sample(input logic signed [31:0] v, input bit miss,
                                           input bit last);
    in_item_t it;
    it.sample = v;
    it.sample_missing = miss;
    it.set_last = last;
    return it;
  endfunction

  // Queues one random set; mostly small values so ties and neighbors are common.
  task automatic queue_random_set(input int unsigned n, input int unsigned miss_pct);
    logic signed [31:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 40)) - 20;
        default: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
      pending_samples.push_back(make_sample(v, $urandom_range(0, 99) < miss_pct,
                                            i + 1 == n));
    end
  endtask

  task automatic random_config();
    write_reg(RegProbCount, $urandom_range(0, 7));
    for (int r = 0; r < 4; r++)
      write_reg(RegProbA + r[2:0], ($urandom_range(0, 9) == 0) ? $urandom
                                   : $urandom_range(0, OneQ16));
    write_reg(RegNaRemove, $urandom);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    cur_prob_count = 1;
    foreach (cur_prob[i]) cur_prob[i] = 32768;
    cur_na_remove = 0;
    clear_collected();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets: extremes of the probabilities and of the sample range.
    write_reg(RegProbCount, 4);
    write_reg(RegProbA, 0);
    write_reg(RegProbB, OneQ16);
    write_reg(RegProbC, 32'h0001_FFFF);
    write_reg(RegProbD, 16385);
    write_reg(RegBad, 32'hFFFF_FFFF);
    write_reg(RegNaRemove, 0);
    pending_samples.push_back(make_sample(32'sh7FFF_FFFF, 0, 1));        // single sample
    pending_samples.push_back(make_sample(32'sh0000_1234, 1, 1));        // single missing
    pending_samples.push_back(make_sample(32'sh8000_0000, 0, 0));
    pending_samples.push_back(make_sample(32'sh7FFF_FFFF, 0, 0));
    pending_samples.push_back(make_sample(-32'sd5, 0, 1));
    pending_samples.push_back(make_sample(32'sd3, 0, 0));
    pending_samples.push_back(make_sample(32'sd9, 1, 1));                // poisoned set
    pending_samples.push_back(make_sample(32'sd1, 1, 0));
    pending_samples.push_back(make_sample(32'sd2, 1, 1));                // all missing
    wait_drained();
    write_reg(RegNaRemove, 1);
    write_reg(RegProbCount, 0);
    pending_samples.push_back(make_sample(32'sd1, 1, 0));
    pending_samples.push_back(make_sample(32'sd2, 1, 1));                // empty after removal
    pending_samples.push_back(make_sample(-32'sd100, 1, 0));
    pending_samples.push_back(make_sample(32'sh8000_0000, 0, 0));
    pending_samples.push_back(make_sample(32'sd7, 0, 1));
    wait_drained();
    sent = 14;

    // Over capacity set: the samples beyond the limit are dropped.
    write_reg(RegProbCount, 3);
    write_reg(RegProbA, $urandom_range(0, OneQ16));
    queue_random_set(MaxSamples + 6, 10);
    sent += MaxSamples + 6;

    // Long hold on the result side while samples keep coming, so the block backs up.
    queue_random_set(5, 0);
    queue_random_set(4, 0);
    queue_random_set(3, 0);
    sent += 12;
    hold_receiver = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_receiver = 1'b0;
    wait_drained();

    // Random phases with a new setting between each, small sets mostly.
    while (sent < 400) begin
      random_config();
      for (int s = 0; s < 8; s++) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, MaxSamples + 3)
                                         : $urandom_range(1, 8);
        queue_random_set(n, $urandom_range(0, 1) ? 0 : 20);
        sent += n;
      end
      wait_drained();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatch_count == 0 && expected_quantiles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/slq_pkg.sv
rtl/core/slq_store.sv
rtl/core/sorted_linear_quantiles.sv
test/sorted_linear_quantiles_tb.sv
